@@ hdl/aam_pkg.sv @@
`timescale 1ns / 1ps

package aam_pkg;

    // Command codes carried by a request.
    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_MARK    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_QUERY   = 2'd3
    } aam_cmd_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVERFLOW   = 2'd1,
        ST_STACK_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } aam_status_t;

    // Configuration register indexes.
    localparam logic REG_ARENA_SIZE = 1'b0;

    // Width of the configuration byte address.
    localparam int PADDR_W = 3;

    // One request.
    typedef struct packed {
        aam_cmd_t    command;
        logic [30:0] alloc_size;
        logic [31:0] release_offset;
    } aam_request_t;

    // One result.
    typedef struct packed {
        aam_status_t status;
        logic [31:0] offset_out;
        logic [31:0] used_bytes;
        logic [31:0] free_bytes;
        logic [9:0]  marks_held;
    } aam_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_read;
        logic scan_step;
        logic commit;
        logic release_hit;
    } aam_dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        aam_cmd_t command;
        logic     stack_empty;
        logic     match;
        logic     scan_last;
    } aam_dp_stat_t;

endpackage

@@ hdl/aam_datapath.sv @@
`timescale 1ns / 1ps

module aam_datapath #(
    parameter int MARK_DEPTH = 1024,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  aam_pkg::aam_request_t request,
    input  logic [31:0]           arena_size,
    input  aam_pkg::aam_dp_cmd_t  cmd,
    output aam_pkg::aam_dp_stat_t stat,
    output aam_pkg::aam_result_t  result
);
    import aam_pkg::*;

    // Offsets never exceed the smaller of the 32-bit arena and the address space.
    localparam int UW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int CW = $clog2(MARK_DEPTH);
    localparam logic [32:0] AMASK = (33'd1 << UW) - 33'd1;
    localparam logic [CW-1:0] COUNT_FULL = CW'(MARK_DEPTH - 1);

    aam_request_t  req_reg;
    logic [UW-1:0] used_reg, used_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_idx_reg;
    logic [UW-1:0] rd_data_reg;
    aam_result_t   result_reg, result_next;

    logic [UW-1:0] mark_mem [MARK_DEPTH];
    logic          mem_we;

    logic [31:0] limit;
    logic [32:0] alloc_sum;
    logic        alloc_fail;
    logic [31:0] used_after;

    // Usable limit: arena size capped at the largest address.
    always_comb
    begin
        limit      = ((arena_size >> UW) != 32'd0) ? AMASK[31:0] : arena_size;
        alloc_sum  = {1'b0, 32'(used_reg)} + {2'b00, req_reg.alloc_size};
        alloc_fail = (arena_size == 32'd0) || (alloc_sum > {1'b0, limit});
    end

    // Status toward the controller.
    always_comb
    begin
        stat.command     = req_reg.command;
        stat.stack_empty = (count_reg == '0);
        stat.match       = (32'(rd_data_reg) == req_reg.release_offset);
        stat.scan_last   = (scan_idx_reg == count_reg - CW'(1));
    end

    // Outcome of the current request, applied on commit.
    always_comb
    begin
        used_next              = used_reg;
        count_next             = count_reg;
        mem_we                 = 1'b0;
        result_next.status     = ST_OK;
        result_next.offset_out = 32'd0;
        case (req_reg.command)
            CMD_ALLOC:
            begin
                if (alloc_fail)
                begin
                    result_next.status = ST_OVERFLOW;
                end
                else
                begin
                    result_next.offset_out = 32'(used_reg);
                    used_next              = alloc_sum[UW-1:0];
                end
            end
            CMD_MARK:
            begin
                if (count_reg >= COUNT_FULL)
                begin
                    result_next.status = ST_STACK_FULL;
                end
                else
                begin
                    mem_we                 = cmd.commit;
                    count_next             = count_reg + CW'(1);
                    result_next.offset_out = 32'(used_reg);
                end
            end
            CMD_RELEASE:
            begin
                if (cmd.release_hit)
                begin
                    used_next  = rd_data_reg;
                    count_next = scan_idx_reg;
                end
                else
                begin
                    result_next.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                result_next.status = ST_OK;
            end
        endcase
        used_after             = 32'(used_next);
        result_next.used_bytes = used_after;
        result_next.free_bytes = (used_after >= arena_size) ? 32'd0
                                                            : arena_size - used_after;
        result_next.marks_held = 10'(count_next);
    end

    // Allocator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            used_reg  <= used_next;
            count_reg <= count_next;
        end
    end

    // Scan index over the mark stack.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_clear)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + CW'(1);
        end
    end

    // Request and result holding registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    // Mark stack memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mark_mem[count_reg] <= used_reg;
        end
        if (cmd.scan_read)
        begin
            rd_data_reg <= mark_mem[scan_idx_reg];
        end
    end

    assign result = result_reg;

    // The stack never holds more than one less than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("mark count beyond stack capacity");

    // Reads only touch pushed marks.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_read |-> (scan_idx_reg < count_reg))
        else $error("mark scan past top of stack");

    // A release restores only a mark that matched.
    a_hit_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && cmd.release_hit) |-> stat.match)
        else $error("release committed without a matching mark");

endmodule

@@ hdl/aam_ctrl.sv @@
`timescale 1ns / 1ps

module aam_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  request_valid,
    output logic                  request_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  aam_pkg::aam_dp_stat_t stat,
    output aam_pkg::aam_dp_cmd_t  cmd
);
    import aam_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_CMP  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free      = !out_valid_reg || result_ready;
    assign request_ready = (state_reg == S_IDLE);
    assign result_valid  = out_valid_reg;

    // Sequencer for one request.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (request_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.command == CMD_RELEASE && !stat.stack_empty)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_READ;
                end
                else if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.scan_read = 1'b1;
                state_next    = S_CMP;
            end
            S_CMP:
            begin
                if (stat.match || stat.scan_last)
                begin
                    if (out_free)
                    begin
                        cmd.commit      = 1'b1;
                        cmd.release_hit = stat.match;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is loaded only into a free result register.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("result overwritten before it was taken");

    // Every commit ends the request and shows a result.
    a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("commit did not finish the request");

    // An accepted request moves straight to execution.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (request_valid && request_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

endmodule

@@ hdl/arena_allocator_with_marks_core.sv @@
`timescale 1ns / 1ps
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+--------------------------------
// request   | request_valid / request_ready    | command, alloc_size, release_offset
// result    | result_valid / result_ready      | status, offset_out, used_bytes,
//           |                                  | free_bytes, marks_held
// config    | APB psel/penable/pwrite, pready  | arena_size at byte address 0
//
// Alloc, mark and query are taken when idle and committed from the execute state.
// A release with marks held clears the scan index, then alternates a registered read
// of one mark stack entry with a compare, from the bottom mark upward, until a mark
// matches or the top mark is compared; with an empty stack it commits like the others.
// Reset clears the used offset, the mark count and the result valid flag.
// A new request is taken while a result waits; a stalled result holds the
// next request at its final step until the result register frees up.

module arena_allocator_with_marks_core #(
    parameter int MARK_DEPTH = 1024,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          request_valid,
    output logic                          request_ready,
    input  aam_pkg::aam_request_t         request,
    output logic                          result_valid,
    input  logic                          result_ready,
    output aam_pkg::aam_result_t          result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aam_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import aam_pkg::*;

    logic [31:0]  arena_size_reg;
    logic         cfg_write;
    aam_dp_cmd_t  dp_cmd;
    aam_dp_stat_t dp_stat;

    // Configuration register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ARENA_SIZE) ? arena_size_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_size_reg <= 32'd0;
        end
        else if (cfg_write && paddr[2] == REG_ARENA_SIZE)
        begin
            arena_size_reg <= pwdata;
        end
    end

    // Controller.
    aam_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .stat          (dp_stat),
        .cmd           (dp_cmd)
    );

    // Datapath with the mark stack.
    aam_datapath #(
        .MARK_DEPTH (MARK_DEPTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .arena_size (arena_size_reg),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .result     (result)
    );

endmodule

@@ dv/tb_arena_allocator_with_marks_core.sv @@
`timescale 1ns / 1ps

module tb_arena_allocator_with_marks_core;

    import aam_pkg::*;

    localparam int MARK_DEPTH   = 1024;
    localparam int ADDR_WIDTH   = 32;
    localparam int RUN_LIMIT    = 400000;
    localparam int HOLD_OFF     = 300;
    localparam int PHASE_LEN    = 75;
    localparam int REG_UNMAPPED = 1;

    localparam logic [PADDR_W-1:0] ARENA_ADDR    = PADDR_W'(REG_ARENA_SIZE) << 2;
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(REG_UNMAPPED) << 2;

    // One line of the directed stimulus table: a register write or a request.
    typedef struct {
        bit                 cfg;
        logic [PADDR_W-1:0] addr;
        logic [31:0]        data;
        aam_request_t       req;
        bit                 checked;
        aam_result_t        want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               request_valid;
    logic               request_ready;
    aam_request_t       request;
    logic               result_valid;
    logic               result_ready;
    aam_result_t        result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow copy of the allocator state and its configuration.
    logic [31:0] arena_bytes;
    logic [31:0] used_off;
    int          mark_cnt;
    logic [31:0] mark_mem [MARK_DEPTH];

    aam_result_t pending_results [$];

    int mismatch_count  = 0;
    int accepted_count  = 0;
    int result_count    = 0;
    int setting_count   = 0;
    int peak_marks      = 0;
    int cycle_count     = 0;
    int hold_off_cycles = 0;
    bit no_gaps         = 1'b0;

    arena_allocator_with_marks_core #(
        .MARK_DEPTH(MARK_DEPTH),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .request_valid(request_valid),
        .request_ready(request_ready),
        .request(request),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Apply one request to the shadow state and return the result it yields.
    function automatic aam_result_t arena_next_result(input aam_request_t rq);
        aam_result_t res;
        logic [32:0] reach;
        bit          found;
        res = '0;
        res.status = ST_OK;
        found = 1'b0;
        case (rq.command)
            CMD_ALLOC:
            begin
                reach = {1'b0, used_off} + 33'(rq.alloc_size);
                if (arena_bytes == 32'd0 || reach > {1'b0, arena_bytes})
                    res.status = ST_OVERFLOW;
                else
                begin
                    res.offset_out = used_off;
                    used_off = reach[31:0];
                end
            end
            CMD_MARK:
            begin
                if (mark_cnt >= MARK_DEPTH - 1)
                    res.status = ST_STACK_FULL;
                else
                begin
                    mark_mem[mark_cnt] = used_off;
                    res.offset_out = used_off;
                    mark_cnt++;
                end
            end
            CMD_RELEASE:
            begin
                // The lowest matching mark wins; it and everything above it go.
                for (int i = 0; i < mark_cnt && !found; i++)
                begin
                    if (mark_mem[i] == rq.release_offset)
                    begin
                        used_off = mark_mem[i];
                        mark_cnt = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                    res.status = ST_NOT_FOUND;
            end
            default:
                ;
        endcase
        res.used_bytes = used_off;
        res.free_bytes = (used_off >= arena_bytes) ? 32'd0 : arena_bytes - used_off;
        res.marks_held = 10'(mark_cnt);
        if (mark_cnt > peak_marks)
            peak_marks = mark_cnt;
        return res;
    endfunction

    function automatic aam_request_t make_request(input aam_cmd_t c, input logic [30:0] sz,
                                                  input logic [31:0] rel);
        aam_request_t rq;
        rq.command = c;
        rq.alloc_size = sz;
        rq.release_offset = rel;
        return rq;
    endfunction

    function automatic stim_row_t req_row(input aam_cmd_t c, input logic [30:0] sz,
                                          input logic [31:0] rel, input bit checked,
                                          input aam_status_t st, input logic [31:0] offs,
                                          input logic [31:0] used, input logic [31:0] freeb,
                                          input logic [9:0] marks);
        stim_row_t row;
        row.cfg = 1'b0;
        row.addr = '0;
        row.data = '0;
        row.req = make_request(c, sz, rel);
        row.checked = checked;
        row.want.status = st;
        row.want.offset_out = offs;
        row.want.used_bytes = used;
        row.want.free_bytes = freeb;
        row.want.marks_held = marks;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        stim_row_t row;
        row.cfg = 1'b1;
        row.addr = addr;
        row.data = data;
        row.req = '0;
        row.checked = 1'b0;
        row.want = '0;
        return row;
    endfunction

    // Random request shaped by the current shadow state: mostly allocations that fit
    // or just miss, pushes, and releases to marks that are really held.
    function automatic aam_request_t random_request();
        aam_request_t rq;
        logic [31:0]  room;
        logic [31:0]  span;
        int           pick;
        int           sub;
        rq.command = CMD_QUERY;
        rq.alloc_size = 31'($urandom());
        rq.release_offset = $urandom();
        room = (used_off >= arena_bytes) ? 32'd0 : arena_bytes - used_off;
        pick = $urandom_range(0, 99);
        sub = $urandom_range(0, 19);
        if (pick < 40)
        begin
            rq.command = CMD_ALLOC;
            if (sub == 0)
                rq.alloc_size = '0;
            else if (sub < 3)
                rq.alloc_size = (room > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : room[30:0];
            else if (sub < 5)
                rq.alloc_size = (room >= 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(room + 1);
            else if (sub > 6)
            begin
                span = (room >> 3) + 32'd8;
                rq.alloc_size = 31'($urandom_range(0, span));
            end
        end
        else if (pick < 60 && mark_cnt < 48)
            rq.command = CMD_MARK;
        else if (pick < 88)
        begin
            rq.command = CMD_RELEASE;
            if (sub < 12 && mark_cnt > 1)
                rq.release_offset = mark_mem[$urandom_range(1, mark_cnt - 1)];
            else if (sub < 14 && mark_cnt > 0)
                rq.release_offset = mark_mem[0];
            else if (sub < 17)
                rq.release_offset = used_off;
        end
        return rq;
    endfunction

    // Offer one request, hold it until accepted, then queue its expected result.
    task automatic issue_request(input aam_request_t rq, input bit checked,
                                 input aam_result_t want);
        int          gap;
        aam_result_t predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            request_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request <= rq;
        request_valid <= 1'b1;
        do @(posedge clk); while (request_ready !== 1'b1);
        predicted = arena_next_result(rq);
        pending_results.push_back(checked ? want : predicted);
        accepted_count++;
    endtask

    // Register write once the block has drained, followed by a read-back.
    task automatic write_arena_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        request_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ARENA_ADDR)
        begin
            arena_bytes = data;
            setting_count++;
        end
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ARENA_ADDR && prdata !== data)
        begin
            $error("prdata: expected %h, got %h", data, prdata);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop back to the bottom mark and push it again, so that small arenas start low.
    task automatic rewind_to_bottom_mark();
        if (mark_cnt > 0)
            issue_request(make_request(CMD_RELEASE, 31'($urandom()), mark_mem[0]), 1'b0, '0);
        issue_request(make_request(CMD_MARK, 31'($urandom()), $urandom()), 1'b0, '0);
    endtask

    // Result side: random stalls per result, plus one long hold-off on request.
    initial
    begin
        int stall;
        result_ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                result_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else
            begin
                stall = no_gaps ? 0 : $urandom_range(0, 5);
                if (stall > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (result_valid !== 1'b1);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        aam_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatch_count++;
                end
                if (result.offset_out !== want.offset_out)
                begin
                    $error("offset_out: expected %h, got %h", want.offset_out, result.offset_out);
                    mismatch_count++;
                end
                if (result.used_bytes !== want.used_bytes)
                begin
                    $error("used_bytes: expected %h, got %h", want.used_bytes, result.used_bytes);
                    mismatch_count++;
                end
                if (result.free_bytes !== want.free_bytes)
                begin
                    $error("free_bytes: expected %h, got %h", want.free_bytes, result.free_bytes);
                    mismatch_count++;
                end
                if (result.marks_held !== want.marks_held)
                begin
                    $error("marks_held: expected %0d, got %0d", want.marks_held,
                           result.marks_held);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   directed_rows [$];
        logic [31:0] arena_plan [$];

        rst_n <= 1'b0;
        request_valid <= 1'b0;
        request <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        arena_bytes = '0;
        used_off = '0;
        mark_cnt = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty arena after reset, exact fit, overflow, zero-byte
        // allocations, release misses and hits, an unmapped register, a shrunk arena
        // and the largest allocation size.
        directed_rows.push_back(req_row(CMD_QUERY, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(req_row(CMD_ALLOC, 5, 0, 1, ST_OVERFLOW, 0, 0, 0, 0));
        directed_rows.push_back(req_row(CMD_RELEASE, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(ARENA_ADDR, 32'd100));
        directed_rows.push_back(req_row(CMD_ALLOC, 0, 0, 1, ST_OK, 0, 0, 100, 0));
        directed_rows.push_back(req_row(CMD_ALLOC, 40, 0, 1, ST_OK, 0, 40, 60, 0));
        directed_rows.push_back(req_row(CMD_MARK, 0, 0, 1, ST_OK, 40, 40, 60, 1));
        directed_rows.push_back(req_row(CMD_ALLOC, 60, 0, 1, ST_OK, 40, 100, 0, 1));
        directed_rows.push_back(req_row(CMD_ALLOC, 1, 0, 1, ST_OVERFLOW, 0, 100, 0, 1));
        directed_rows.push_back(req_row(CMD_ALLOC, 0, 0, 1, ST_OK, 100, 100, 0, 1));
        directed_rows.push_back(req_row(CMD_RELEASE, 0, 41, 1, ST_NOT_FOUND, 0, 100, 0, 1));
        directed_rows.push_back(req_row(CMD_RELEASE, 0, 40, 1, ST_OK, 0, 40, 60, 0));
        directed_rows.push_back(req_row(CMD_MARK, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(req_row(CMD_ALLOC, 10, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(req_row(CMD_MARK, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(req_row(CMD_RELEASE, 0, 40, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(UNMAPPED_ADDR, 32'd7));
        directed_rows.push_back(req_row(CMD_QUERY, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK,
                                        0, 40, 60, 0));
        directed_rows.push_back(req_row(CMD_MARK, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(ARENA_ADDR, 32'd20));
        directed_rows.push_back(req_row(CMD_QUERY, 0, 0, 1, ST_OK, 0, 40, 0, 1));
        directed_rows.push_back(req_row(CMD_ALLOC, 0, 0, 1, ST_OVERFLOW, 0, 40, 0, 1));
        directed_rows.push_back(req_row(CMD_ALLOC, 1, 0, 1, ST_OVERFLOW, 0, 40, 0, 1));
        directed_rows.push_back(cfg_row(ARENA_ADDR, 32'hFFFF_FFFF));
        directed_rows.push_back(req_row(CMD_ALLOC, 31'h7FFF_FFFF, 0, 1, ST_OK,
                                        40, 32'h8000_0027, 32'h7FFF_FFD8, 1));
        directed_rows.push_back(req_row(CMD_ALLOC, 31'h7FFF_FFFF, 0, 1, ST_OVERFLOW,
                                        0, 32'h8000_0027, 32'h7FFF_FFD8, 1));
        directed_rows.push_back(req_row(CMD_MARK, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(req_row(CMD_RELEASE, 0, 32'h8000_0027, 0, ST_OK, 0, 0, 0, 0));

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].cfg)
                write_arena_reg(directed_rows[r].addr, directed_rows[r].data);
            else
                issue_request(directed_rows[r].req, directed_rows[r].checked,
                              directed_rows[r].want);
        end

        // Random part, one arena size per phase. The second phase starts with a long
        // result stall; part of the third runs with no idle cycles on either side.
        arena_plan = '{32'hFFFF_FFFF, 32'd4096, 32'd64, $urandom(), 32'd1,
                       32'h7FFF_FFFF, 32'd0};
        foreach (arena_plan[p])
        begin
            write_arena_reg(ARENA_ADDR, arena_plan[p]);
            rewind_to_bottom_mark();
            if (p == 1)
                hold_off_cycles = HOLD_OFF;
            no_gaps = (p == 2);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (n == 40)
                    no_gaps = 1'b0;
                issue_request(random_request(), 1'b0, '0);
            end
        end

        // Drain and report.
        request_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Checked %0d requests and %0d results under %0d arena size settings.",
                 accepted_count, result_count, setting_count);
        $display("Mark stack peaked at %0d of %0d usable entries; %0d mismatches seen.",
                 peak_marks, MARK_DEPTH - 1, mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
